### rtl/core/assert_macros.svh
// Assertion macros used by the parser RTL.
// Each macro expects clk_i and rst_ni to be visible in the using module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define GCPP_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define GCPP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/gcpp_pkg.sv
// Shared types and constants for the command packet parser.
// No dependencies; imported by every parser module.
`timescale 1ns / 1ps
`default_nettype none

package gcpp_pkg;

  localparam int unsigned RegCount  = 32768;
  localparam int unsigned WordW     = 32;
  localparam int unsigned TargetW   = 16;
  localparam int unsigned CountW    = 15;
  localparam int unsigned OutDataW  = 56;

  typedef enum logic [1:0] {
    PKT_TYPE0 = 2'd0,
    PKT_TYPE1 = 2'd1,
    PKT_TYPE2 = 2'd2,
    PKT_TYPE3 = 2'd3
  } pkt_type_e;

  typedef enum logic [1:0] {
    KIND_REG_WRITE = 2'd0,
    KIND_CMD_HDR   = 2'd1,
    KIND_CMD_DATA  = 2'd2,
    KIND_RESERVED  = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e                kind;
    logic [TargetW-1:0]   target;
    logic [WordW-1:0]     payload;
    logic                 accepted;
    logic                 last;
  } result_t;

endpackage

`default_nettype wire

### rtl/core/gcpp_in_stage.sv
// Input register for ring words, with its own valid bit.
// Depends on gcpp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gcpp_in_stage
  import gcpp_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [WordW-1:0] in_word_i,
  input  wire logic             take_i,
  output logic                  word_valid_o,
  output logic [WordW-1:0]      word_o
);

  logic             vld_q, vld_d;
  logic [WordW-1:0] word_q;

  // Free when empty or when the held word is consumed this cycle.
  assign in_ready_o = !vld_q || take_i;

  always_comb begin
    vld_d = vld_q;
    if (take_i) vld_d = 1'b0;
    if (in_valid_i && in_ready_o) vld_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) word_q <= in_word_i;
  end

  assign word_valid_o = vld_q;
  assign word_o       = word_q;

endmodule

`default_nettype wire

### rtl/core/gcpp_parser.sv
// Packet framing state and header decode for one ring word per step.
// Depends on gcpp_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module gcpp_parser
  import gcpp_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic [WordW-1:0] word_i,
  input  wire logic             step_i,
  output logic                  res_valid_o,
  output result_t               res_o
);

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_REGDATA = 2'd1,
    PH_CMDDATA = 2'd2
  } phase_e;

  phase_e             phase_q, phase_d;
  logic [CountW-1:0]  words_left_q, words_left_d;
  logic [TargetW-1:0] next_index_q, next_index_d;
  logic               same_reg_q, same_reg_d;
  logic [7:0]         opcode_q, opcode_d;

  logic               fin;
  logic [13:0]        cnt;
  pkt_type_e          ptype;

  assign fin   = (words_left_q <= CountW'(1));
  assign cnt   = word_i[29:16];
  assign ptype = pkt_type_e'(word_i[31:30]);

  always_comb begin
    phase_d      = phase_q;
    words_left_d = words_left_q;
    next_index_d = next_index_q;
    same_reg_d   = same_reg_q;
    opcode_d     = opcode_q;
    res_valid_o  = 1'b0;
    res_o        = '{kind: KIND_RESERVED, target: '0, payload: '0, accepted: 1'b0,
                     last: 1'b0};
    case (phase_q)
      PH_REGDATA: begin
        res_valid_o  = 1'b1;
        res_o.kind     = KIND_REG_WRITE;
        res_o.target   = next_index_q;
        res_o.payload  = word_i;
        res_o.accepted = ({1'b0, next_index_q} < 17'(RegCount));
        res_o.last     = fin;
        if (!same_reg_q) next_index_d = next_index_q + TargetW'(1);
        words_left_d = fin ? '0 : words_left_q - CountW'(1);
        if (fin) phase_d = PH_HEADER;
      end
      PH_CMDDATA: begin
        res_valid_o  = 1'b1;
        res_o.kind     = KIND_CMD_DATA;
        res_o.target   = {8'd0, opcode_q};
        res_o.payload  = word_i;
        res_o.last     = fin;
        words_left_d = fin ? '0 : words_left_q - CountW'(1);
        if (fin) phase_d = PH_HEADER;
      end
      default: begin
        // Header word; the unused phase code lands here too.
        phase_d = PH_HEADER;
        case (ptype)
          PKT_TYPE0: begin
            next_index_d = {1'b0, word_i[14:0]};
            same_reg_d   = word_i[15];
            words_left_d = {1'b0, cnt} + CountW'(1);
            phase_d      = PH_REGDATA;
          end
          PKT_TYPE1: begin
            res_valid_o = 1'b1;
            res_o.kind  = KIND_RESERVED;
            res_o.last  = 1'b1;
          end
          PKT_TYPE3: begin
            opcode_d      = word_i[7:0];
            res_valid_o   = 1'b1;
            res_o.kind    = KIND_CMD_HDR;
            res_o.target  = {8'd0, word_i[7:0]};
            res_o.payload = {18'd0, cnt};
            res_o.last    = (cnt == '0);
            if (cnt != '0) begin
              words_left_d = {1'b0, cnt};
              phase_d      = PH_CMDDATA;
            end
          end
          default: begin
            // Filler: consume, give nothing.
          end
        endcase
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_HEADER;
      words_left_q <= '0;
      next_index_q <= '0;
      same_reg_q   <= 1'b0;
      opcode_q     <= '0;
    end else if (step_i) begin
      phase_q      <= phase_d;
      words_left_q <= words_left_d;
      next_index_q <= next_index_d;
      same_reg_q   <= same_reg_d;
      opcode_q     <= opcode_d;
    end
  end

  `GCPP_ASSERT_SAME(a_data_phase_has_words, phase_q != PH_HEADER, words_left_q != '0, "data phase with no words left")
  `GCPP_ASSERT_NEXT(a_final_word_ends_packet, step_i && phase_q != PH_HEADER && fin, phase_q == PH_HEADER, "packet did not close after its final word")
  `GCPP_ASSERT_NEXT(a_type0_opens_data, step_i && phase_q == PH_HEADER && ptype == PKT_TYPE0, phase_q == PH_REGDATA && words_left_q == {1'b0, $past(cnt)} + CountW'(1), "type 0 header did not open register data")

endmodule

`default_nettype wire

### rtl/core/gcpp_out_stage.sv
// Result register feeding the master-side stream.
// Depends on gcpp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gcpp_out_stage
  import gcpp_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    load_i,
  input  wire result_t res_i,
  output logic         space_o,
  output logic         out_valid_o,
  input  wire logic    out_ready_i,
  output result_t      res_o
);

  logic    vld_q, vld_d;
  result_t res_q;

  assign space_o = !vld_q || out_ready_i;

  always_comb begin
    vld_d = vld_q;
    if (out_ready_i) vld_d = 1'b0;
    if (load_i)      vld_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) res_q <= res_i;
  end

  assign out_valid_o = vld_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

### rtl/core/gpu_command_packet_parser_core.sv
// Top level of the command packet parser: input register, decode, result register.
// Depends on gcpp_pkg, gcpp_in_stage, gcpp_parser and gcpp_out_stage.
//
//  channel   dir  tdata (low bit up)                         tuser  tlast
//  s_axis    in   ring_word[31:0]                            -      -
//  m_axis    out  target[15:0] payload[47:16] accepted[48]   kind   last
//
// Each ring word is decoded combinationally; one word is accepted per cycle
// when the result side keeps up. An input word is held in the input register,
// and its result in the output register. Header words of type 0 and type 2 give
// no result and never wait on the master side. A stalled result holds in the
// output register while one more word is taken into the input register. Reset
// clears all framing state and both valid bits; the parser then expects a header.
`timescale 1ns / 1ps
`default_nettype none

module gpu_command_packet_parser_core
  import gcpp_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // ring_word[31:0]
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  input  wire logic [WordW-1:0]    s_axis_tdata,
  // target[15:0], payload[47:16], accepted[48], zero fill above
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output logic [OutDataW-1:0]      m_axis_tdata,
  // kind[1:0]
  output logic [1:0]               m_axis_tuser,
  output logic                     m_axis_tlast
);

  logic             word_valid;
  logic [WordW-1:0] word;
  logic             res_valid;
  result_t          res;
  logic             out_space;
  logic             step;
  result_t          out_res;

  // Advance the held word when its result, if any, has room downstream.
  assign step = word_valid && (!res_valid || out_space);

  gcpp_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_word_i    (s_axis_tdata),
    .take_i       (step),
    .word_valid_o (word_valid),
    .word_o       (word)
  );

  gcpp_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .word_i      (word),
    .step_i      (step),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  gcpp_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (step && res_valid),
    .res_i       (res),
    .space_o     (out_space),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .res_o       (out_res)
  );

  // Pack the result fields; zero-fill up to whole bytes.
  assign m_axis_tdata = {7'd0, out_res.accepted, out_res.payload, out_res.target};
  assign m_axis_tuser = out_res.kind;
  assign m_axis_tlast = out_res.last;

endmodule

`default_nettype wire
